// ===== hw/rtl/punrank_pkg.sv =====
`timescale 1ns / 1ps

package punrank_pkg;

    // Largest supported permutation and the field widths that follow from it.
    localparam int MAX_ELEMENTS = 20;
    localparam int ELEM_W       = 5;
    localparam int RANK_W       = 63;
    localparam int SIZE_W       = 5;
    localparam int STEP_W       = 3;

    // A digit is below the count of unused values, so it fits in ELEM_W bits
    // and one restoring division step is taken per digit bit.
    localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(ELEM_W - 1);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Factorial of idx; indexes above MAX_ELEMENTS are never requested.
    function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] idx);
        logic [RANK_W-1:0] f;
        case (idx)
            5'd0:    f = 63'd1;
            5'd1:    f = 63'd1;
            5'd2:    f = 63'd2;
            5'd3:    f = 63'd6;
            5'd4:    f = 63'd24;
            5'd5:    f = 63'd120;
            5'd6:    f = 63'd720;
            5'd7:    f = 63'd5040;
            5'd8:    f = 63'd40320;
            5'd9:    f = 63'd362880;
            5'd10:   f = 63'd3628800;
            5'd11:   f = 63'd39916800;
            5'd12:   f = 63'd479001600;
            5'd13:   f = 63'd6227020800;
            5'd14:   f = 63'd87178291200;
            5'd15:   f = 63'd1307674368000;
            5'd16:   f = 63'd20922789888000;
            5'd17:   f = 63'd355687428096000;
            5'd18:   f = 63'd6402373705728000;
            5'd19:   f = 63'd121645100408832000;
            5'd20:   f = 63'd2432902008176640000;
            default: f = 63'd1;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/permutation_unrank_core.sv =====
`timescale 1ns / 1ps

// Channel    Direction  Signals                          Transaction when
// command    in         start, busy, rank                start high, busy low
// result     out        result_valid, element, last,     result_valid high
//                       bad_rank
// config     in         cfg_valid, cfg_ready, cfg_data   cfg_valid and cfg_ready high
//
// After acceptance a rank passes one range check, then per element five
// restoring division steps on the shared shift/compare/subtract unit and one
// emit step that picks the value and shows it as a result.
// An out-of-range rank gives its single result, registered from the range check.
// Reset restores the size register to 8 and returns the sequencer to idle.
// busy stays high until the last result is shown; the result side cannot stall.
module permutation_unrank_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [punrank_pkg::RANK_W-1:0]   rank,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [punrank_pkg::SIZE_W-1:0]   cfg_data,
    output logic                             result_valid,
    output logic [punrank_pkg::ELEM_W-1:0]   element,
    output logic                             last,
    output logic                             bad_rank
);
    import punrank_pkg::*;

    state_t state_reg, state_next;

    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] size_eff;
    logic [RANK_W-1:0] rem_reg, rem_next;
    logic [RANK_W-1:0] weight_reg, weight_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [ELEM_W-1:0] digit_reg, digit_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [ELEM_W-1:0] list_reg [MAX_ELEMENTS];
    logic [ELEM_W-1:0] list_next [MAX_ELEMENTS];

    logic              res_valid_reg, res_valid_next;
    logic [ELEM_W-1:0] res_elem_reg, res_elem_next;
    logic              res_last_reg, res_last_next;
    logic              res_bad_reg, res_bad_next;

    logic [RANK_W-1:0] shifted_weight;
    logic              sub_ok;
    logic              rank_bad;
    logic [ELEM_W-1:0] picked;

    // Effective element count: zero acts as one, anything too large is clamped.
    always_comb
    begin
        if (size_reg == '0)
            size_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(MAX_ELEMENTS))
            size_eff = SIZE_W'(MAX_ELEMENTS);
        else
            size_eff = size_reg;
    end

    // Shared division unit: one shift, compare and subtract per cycle.
    assign shifted_weight = weight_reg << step_reg;
    assign sub_ok         = (rem_reg >= shifted_weight);
    assign rank_bad       = (rem_reg >= fact(count_reg));

    // Select the digit-th unused value from the ascending list.
    always_comb
    begin
        picked = '0;
        for (int j = 0; j < MAX_ELEMENTS; j++)
        begin
            if (digit_reg == ELEM_W'(j))
                picked = list_reg[j];
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = rank_bad ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = (count_reg == SIZE_W'(1)) ? ST_IDLE : ST_DIV;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result register updates for each state.
    always_comb
    begin
        rem_next       = rem_reg;
        weight_next    = weight_reg;
        count_next     = count_reg;
        digit_next     = digit_reg;
        step_next      = step_reg;
        list_next      = list_reg;
        res_valid_next = 1'b0;
        res_elem_next  = res_elem_reg;
        res_last_next  = res_last_reg;
        res_bad_next   = res_bad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = rank;
                    count_next = size_eff;
                    for (int j = 0; j < MAX_ELEMENTS; j++)
                        list_next[j] = ELEM_W'(j + 1);
                end
            end
            ST_CHECK:
            begin
                digit_next  = '0;
                step_next   = TOP_STEP;
                weight_next = fact(count_reg - SIZE_W'(1));
                if (rank_bad)
                begin
                    res_valid_next = 1'b1;
                    res_elem_next  = '0;
                    res_last_next  = 1'b1;
                    res_bad_next   = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (sub_ok)
                begin
                    rem_next             = rem_reg - shifted_weight;
                    digit_next[step_reg] = 1'b1;
                end
                if (step_reg != '0)
                    step_next = step_reg - STEP_W'(1);
            end
            ST_EMIT:
            begin
                res_valid_next = 1'b1;
                res_elem_next  = picked;
                res_last_next  = (count_reg == SIZE_W'(1));
                res_bad_next   = 1'b0;
                // Close the gap left by the taken value.
                for (int j = 0; j < MAX_ELEMENTS - 1; j++)
                begin
                    if (ELEM_W'(j) >= digit_reg)
                        list_next[j] = list_reg[j + 1];
                end
                count_next  = count_reg - SIZE_W'(1);
                digit_next  = '0;
                step_next   = TOP_STEP;
                weight_next = (count_reg >= SIZE_W'(2)) ?
                              fact(count_reg - SIZE_W'(2)) : weight_reg;
            end
            default:
            begin
                rem_next = rem_reg;
            end
        endcase
    end

    // Control registers and the configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
                size_reg <= cfg_data;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        weight_reg   <= weight_next;
        count_reg    <= count_next;
        digit_reg    <= digit_next;
        step_reg     <= step_next;
        list_reg     <= list_next;
        res_elem_reg <= res_elem_next;
        res_last_reg <= res_last_next;
        res_bad_reg  <= res_bad_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign element      = res_elem_reg;
    assign last         = res_last_reg;
    assign bad_rank     = res_bad_reg;

`ifndef SYNTHESIS
    // An accepted rank always makes the block busy on the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted rank did not raise busy");

    // Returning to idle always coincides with the final result of a rank.
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("idle reached without a final result");

    // An out-of-range result is a lone final result with a zero element.
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_rank) |-> (last && element == '0))
        else $error("malformed out-of-range result");

    // A normal result carries a one-based value within the supported size.
    a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !bad_rank) |->
            (element != '0 && element <= ELEM_W'(MAX_ELEMENTS)))
        else $error("element out of range");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import punrank_pkg::*;

    // One permutation element as it appears on the result ports.
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              last;
        logic              bad_rank;
    } perm_elem_t;

    // How the expected elements of a directed row are formed.
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_ASCEND,
        ROW_DESCEND,
        ROW_BAD
    } row_kind_t;

    typedef struct packed {
        logic              wr_size;
        logic [SIZE_W-1:0] size_val;
        logic [RANK_W-1:0] rank_val;
        row_kind_t         kind;
    } unrank_row_t;

    localparam int NUM_ROWS     = 20;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 18;
    localparam int DRAIN_CYCLES = 2 + 6 * MAX_ELEMENTS + 8;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              start        = 1'b0;
    logic              busy;
    logic [RANK_W-1:0] rank         = '0;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data     = '0;
    logic              result_valid;
    logic [ELEM_W-1:0] element;
    logic              last;
    logic              bad_rank;

    // Local copy of the size register and the elements still owed by the block.
    logic [SIZE_W-1:0] size_reg = SIZE_RESET;
    perm_elem_t        pending_elems[$];
    int                mismatch_count = 0;

    // Directed rows: reset size first, then the size extremes and range edges.
    unrank_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, 5'd0,  63'd0,                           ROW_ASCEND},
        '{1'b0, 5'd0,  63'd40319,                       ROW_DESCEND},
        '{1'b0, 5'd0,  63'd40320,                       ROW_BAD},
        '{1'b0, 5'd0,  63'h7FFF_FFFF_FFFF_FFFF,         ROW_BAD},
        '{1'b0, 5'd0,  63'd12345,                       ROW_MODEL},
        '{1'b1, 5'd0,  63'd0,                           ROW_ASCEND},
        '{1'b0, 5'd0,  63'd1,                           ROW_BAD},
        '{1'b1, 5'd1,  63'd0,                           ROW_ASCEND},
        '{1'b1, 5'd20, 63'd0,                           ROW_ASCEND},
        '{1'b0, 5'd0,  63'd2432902008176639999,         ROW_DESCEND},
        '{1'b0, 5'd0,  63'd2432902008176640000,         ROW_BAD},
        '{1'b0, 5'd0,  63'h1555_5555_5555_5555,         ROW_MODEL},
        '{1'b1, 5'd31, 63'd2432902008176639999,         ROW_DESCEND},
        '{1'b0, 5'd0,  63'd1,                           ROW_MODEL},
        '{1'b1, 5'd21, 63'd2432902008176640000,         ROW_BAD},
        '{1'b1, 5'd2,  63'd0,                           ROW_ASCEND},
        '{1'b0, 5'd0,  63'd1,                           ROW_DESCEND},
        '{1'b0, 5'd0,  63'd2,                           ROW_BAD},
        '{1'b1, 5'd3,  63'd3,                           ROW_MODEL},
        '{1'b0, 5'd0,  63'd5,                           ROW_DESCEND}
    };

    permutation_unrank_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .rank         (rank),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .element      (element),
        .last         (last),
        .bad_rank     (bad_rank)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Element count actually used: zero counts as one, oversize is clamped.
    function automatic int active_size(input logic [SIZE_W-1:0] size_val);
        int n;
        n = int'(size_val);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_ELEMENTS)
        begin
            n = MAX_ELEMENTS;
        end
        return n;
    endfunction

    function automatic longint unsigned factorial(input int n);
        longint unsigned prod;
        prod = 1;
        for (int k = 2; k <= n; k++)
        begin
            prod = prod * longint'(k);
        end
        return prod;
    endfunction

    // Append one expected element at the tail of the queue.
    task automatic queue_expected(input perm_elem_t elem);
        pending_elems.insert(pending_elems.size(), elem);
    endtask

    // Decode a rank in the factorial number system and queue its elements.
    task automatic predict_permutation(input logic [RANK_W-1:0] rank_val);
        longint unsigned weight;
        longint unsigned rem;
        longint unsigned digit;
        longint unsigned seen;
        logic [MAX_ELEMENTS-1:0] used;
        int n;
        int pick;
        logic found;
        n = active_size(size_reg);
        weight = factorial(n);
        rem = {1'b0, rank_val};
        used = '0;
        if (rem >= weight)
        begin
            queue_expected('{'0, 1'b1, 1'b1});
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                weight = weight / longint'(n - i);
                digit = rem / weight;
                rem = rem - digit * weight;
                seen = 0;
                pick = 0;
                found = 1'b0;
                for (int v = 0; v < n; v++)
                begin
                    if (!used[v] && !found)
                    begin
                        if (seen == digit)
                        begin
                            pick = v;
                            found = 1'b1;
                        end
                        seen++;
                    end
                end
                used[pick] = 1'b1;
                queue_expected('{ELEM_W'(pick + 1), (i == n - 1), 1'b0});
            end
        end
    endtask

    // Expected elements written out directly for the easy directed rows.
    task automatic push_literal(input row_kind_t kind);
        int n;
        n = active_size(size_reg);
        case (kind)
            ROW_ASCEND:
            begin
                for (int k = 1; k <= n; k++)
                begin
                    queue_expected('{ELEM_W'(k), (k == n), 1'b0});
                end
            end
            ROW_DESCEND:
            begin
                for (int k = n; k >= 1; k--)
                begin
                    queue_expected('{ELEM_W'(k), (k == 1), 1'b0});
                end
            end
            default:
            begin
                queue_expected('{'0, 1'b1, 1'b1});
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input perm_elem_t want,
                                   input perm_elem_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%0t: %s: expected element=%0d last=%0b bad_rank=%0b,",
                     $realtime, what, want.element, want.last, want.bad_rank);
            $display("    got element=%0d last=%0b bad_rank=%0b",
                     got.element, got.last, got.bad_rank);
        end
    endtask

    // Offer a rank and return at the edge where the transaction is taken.
    // start is left high so a following rank can go out without a gap.
    task automatic issue_rank(input logic [RANK_W-1:0] rank_val);
        start <= 1'b1;
        rank <= rank_val;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Let every owed element arrive, then pause so the block is idle.
    task automatic drain_block();
        start <= 1'b0;
        while (pending_elems.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] size_val);
        cfg_valid <= 1'b1;
        cfg_data <= size_val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        size_reg = size_val;
    endtask

    // Result checker: each strobed element is compared with the oldest expected one.
    always @(posedge clk)
    begin
        perm_elem_t got;
        perm_elem_t want;
        if (rst_n && result_valid)
        begin
            got = '{element, last, bad_rank};
            if (pending_elems.size() == 0)
            begin
                report_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = pending_elems.pop_front();
                if (got !== want)
                begin
                    report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Main stimulus: directed table, then random phases with fresh sizes.
    initial
    begin
        logic [RANK_W-1:0] rank_val;
        logic [63:0] raw;
        longint unsigned limit;
        logic idle_on;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            if (directed_rows[r].wr_size)
            begin
                drain_block();
                write_size(directed_rows[r].size_val);
            end
            issue_rank(directed_rows[r].rank_val);
            if (directed_rows[r].kind == ROW_MODEL)
            begin
                predict_permutation(directed_rows[r].rank_val);
            end
            else
            begin
                push_literal(directed_rows[r].kind);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_block();
            if ($urandom_range(0, 1) == 0)
            begin
                write_size(SIZE_W'($urandom_range(1, 8)));
            end
            else
            begin
                write_size(SIZE_W'($urandom_range(0, 31)));
            end
            n = active_size(size_reg);
            limit = factorial(n);
            // The final phase runs back to back; earlier ones may switch idling off.
            idle_on = (p < NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                raw = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0: rank_val = raw[RANK_W-1:0];
                    1: rank_val = RANK_W'(limit - 1 + longint'($urandom_range(0, 3)));
                    default: rank_val = RANK_W'(raw % limit);
                endcase
                if (idle_on && $urandom_range(0, 2) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge clk);
                end
                issue_rank(rank_val);
                predict_permutation(rank_val);
            end
        end

        drain_block();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_elems.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== permutation_unrank_core.f =====
hw/rtl/punrank_pkg.sv
hw/rtl/permutation_unrank_core.sv
tb/tb.sv
